/* rtl/tbsw_pkg.sv */
// ----------------------------------------------------------------------------
// tbsw_pkg
// shared widths, register codes and types of the tile buffer scroll window
// ----------------------------------------------------------------------------
package tbsw_pkg;

	localparam int BUFFER_WIDTH_DEF  = 512;
	localparam int BUFFER_HEIGHT_DEF = 1024;

	localparam int POS_W    = 16;
	localparam int VIEW_W_W = 10;
	localparam int VIEW_H_W = 11;
	localparam int WIN_X_W  = 9;
	localparam int WIN_Y_W  = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int CALC_W   = 19;

	localparam logic [VIEW_W_W-1:0] VIEW_W_RST = VIEW_W_W'(240);
	localparam logic [VIEW_H_W-1:0] VIEW_H_RST = VIEW_H_W'(240);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_WIDTH  = 1'b0,
		REG_VIEW_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_BLIT    = 1'b0,
		ACT_REPAINT = 1'b1
	} action_t;

	typedef struct packed {
		logic [POS_W-1:0]         pos;
		logic                     in_buf;
		logic [POS_W-1:0]         rep_render;
		logic signed [CALC_W-1:0] rep_offset;
		logic signed [CALC_W-1:0] blit_offset;
	} axis_res_t;

endpackage

/* rtl/tbsw_if.sv */
// ----------------------------------------------------------------------------
// tbsw_if
// handshake channels of the tile buffer scroll window: step, result, config
// ----------------------------------------------------------------------------
interface tbsw_step_if import tbsw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] delta_x;
	logic signed [POS_W-1:0] delta_y;
	logic [POS_W-1:0]        content_width;
	logic [POS_W-1:0]        content_height;

	modport source (output valid, delta_x, delta_y, content_width, content_height,
		input ready);
	modport sink (input valid, delta_x, delta_y, content_width, content_height,
		output ready);
endinterface

interface tbsw_result_if import tbsw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   scroll_x;
	logic [POS_W-1:0]   scroll_y;
	logic [WIN_X_W-1:0] window_x;
	logic [WIN_Y_W-1:0] window_y;
	logic [POS_W-1:0]   origin_x;
	logic [POS_W-1:0]   origin_y;
	logic               action;

	modport source (output valid, scroll_x, scroll_y, window_x, window_y, origin_x,
		origin_y, action, input ready);
	modport sink (input valid, scroll_x, scroll_y, window_x, window_y, origin_x,
		origin_y, action, output ready);
endinterface

interface tbsw_cfg_if import tbsw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tbsw_axis.sv */
// ----------------------------------------------------------------------------
// tbsw_axis
// one axis: scroll clamp, in-buffer test and three-zone window placement
// ----------------------------------------------------------------------------
module tbsw_axis import tbsw_pkg::*; #(
	parameter int BUF    = BUFFER_WIDTH_DEF,
	parameter int VREG_W = VIEW_W_W
) (
	input  logic [POS_W-1:0]        pos,
	input  logic [POS_W-1:0]        render,
	input  logic signed [POS_W-1:0] delta,
	input  logic [POS_W-1:0]        content,
	input  logic [VREG_W-1:0]       view_reg,
	output axis_res_t               res
);

	localparam logic signed [CALC_W-1:0] BUF_C = CALC_W'(BUF);

	logic signed [CALC_W-1:0] vw_raw, vw, cont, maxp, p_sum, p, rnd, o;
	logic signed [CALC_W-1:0] span, center, last_raw, last, off_raw, zone, r_new;

	always_comb begin
		vw_raw = CALC_W'(view_reg);
		priority if (vw_raw < CALC_W'(1)) begin
			vw = CALC_W'(1);
		end else if (vw_raw > BUF_C) begin
			vw = BUF_C;
		end else begin
			vw = vw_raw;
		end

		cont = CALC_W'(content);
		maxp = (cont > vw) ? cont - vw : '0;

		// scroll position clamp
		p_sum = CALC_W'(pos) + CALC_W'(delta);
		priority if (p_sum < 0) begin
			p = '0;
		end else if (p_sum > maxp) begin
			p = maxp;
		end else begin
			p = p_sum;
		end

		rnd = CALC_W'(render);
		o   = p - rnd;
		span = BUF_C - vw;
		center = span >>> 1;

		// three-zone placement
		last_raw = cont - p - vw;
		last     = (last_raw < 0) ? '0 : last_raw;
		off_raw  = span - last;
		priority if (p < center) begin
			zone = p;
		end else if (last < span - center) begin
			zone = (off_raw < center) ? center : ((off_raw > span) ? span : off_raw);
		end else begin
			zone = center;
		end

		r_new = p - zone;

		res.pos         = p[POS_W-1:0];
		res.in_buf      = (o >= 0) && (o <= span);
		res.blit_offset = o;
		if (r_new < 0) begin
			res.rep_render = '0;
			res.rep_offset = p;
		end else begin
			res.rep_render = r_new[POS_W-1:0];
			res.rep_offset = zone;
		end
	end

endmodule

/* rtl/tile_buffer_scroll_window_unit.sv */
// ----------------------------------------------------------------------------
// tile_buffer_scroll_window_unit
// scroll position tracking with tile buffer blit or repaint decision
// ----------------------------------------------------------------------------
// step path: input reg, then result reg; position and origin feedback is registered
// throughput: one step per cycle while the result is not stalled
// reset: position and render origin cleared, view size 240 x 240, both channels empty
// config writes are taken every cycle
module tile_buffer_scroll_window_unit import tbsw_pkg::*; #(
	parameter int BUFFER_WIDTH  = BUFFER_WIDTH_DEF,
	parameter int BUFFER_HEIGHT = BUFFER_HEIGHT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	tbsw_cfg_if.sink      cfg,
	tbsw_step_if.sink     step,
	tbsw_result_if.source result
);

	logic [VIEW_W_W-1:0] view_w_q;
	logic [VIEW_H_W-1:0] view_h_q;
	logic [POS_W-1:0]    pos_x_q, pos_y_q, render_x_q, render_y_q;

	logic                    v_s1;
	logic signed [POS_W-1:0] dx_s1, dy_s1;
	logic [POS_W-1:0]        cw_s1, ch_s1;

	logic               v_s2;
	logic [POS_W-1:0]   scroll_x_s2, scroll_y_s2, origin_x_s2, origin_y_s2;
	logic [WIN_X_W-1:0] window_x_s2;
	logic [WIN_Y_W-1:0] window_y_s2;
	action_t            action_s2;

	axis_res_t ax, ay;
	logic      adv, in_buf;

	assign adv        = v_s1 && (!v_s2 || result.ready);
	assign step.ready = !v_s1 || adv;
	assign cfg.ready  = 1'b1;
	assign in_buf     = ax.in_buf && ay.in_buf;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_w_q <= VIEW_W_RST;
			view_h_q <= VIEW_H_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_VIEW_WIDTH:  view_w_q <= cfg.data[VIEW_W_W-1:0];
				REG_VIEW_HEIGHT: view_h_q <= cfg.data[VIEW_H_W-1:0];
				default:         ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (step.ready) begin
			v_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			dx_s1 <= step.delta_x;
			dy_s1 <= step.delta_y;
			cw_s1 <= step.content_width;
			ch_s1 <= step.content_height;
		end
	end

	tbsw_axis #(.BUF(BUFFER_WIDTH), .VREG_W(VIEW_W_W)) u_axis_x (
		.pos      (pos_x_q),
		.render   (render_x_q),
		.delta    (dx_s1),
		.content  (cw_s1),
		.view_reg (view_w_q),
		.res      (ax)
	);

	tbsw_axis #(.BUF(BUFFER_HEIGHT), .VREG_W(VIEW_H_W)) u_axis_y (
		.pos      (pos_y_q),
		.render   (render_y_q),
		.delta    (dy_s1),
		.content  (ch_s1),
		.view_reg (view_h_q),
		.res      (ay)
	);

	// scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			render_x_q <= '0;
			render_y_q <= '0;
		end else if (adv) begin
			pos_x_q <= ax.pos;
			pos_y_q <= ay.pos;
			if (!in_buf) begin
				render_x_q <= ax.rep_render;
				render_y_q <= ay.rep_render;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (result.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scroll_x_s2 <= ax.pos;
			scroll_y_s2 <= ay.pos;
			if (in_buf) begin
				window_x_s2 <= ax.blit_offset[WIN_X_W-1:0];
				window_y_s2 <= ay.blit_offset[WIN_Y_W-1:0];
				origin_x_s2 <= render_x_q;
				origin_y_s2 <= render_y_q;
				action_s2   <= ACT_BLIT;
			end else begin
				window_x_s2 <= ax.rep_offset[WIN_X_W-1:0];
				window_y_s2 <= ay.rep_offset[WIN_Y_W-1:0];
				origin_x_s2 <= ax.rep_render;
				origin_y_s2 <= ay.rep_render;
				action_s2   <= ACT_REPAINT;
			end
		end
	end

	assign result.valid    = v_s2;
	assign result.scroll_x = scroll_x_s2;
	assign result.scroll_y = scroll_y_s2;
	assign result.window_x = window_x_s2;
	assign result.window_y = window_y_s2;
	assign result.origin_x = origin_x_s2;
	assign result.origin_y = origin_y_s2;
	assign result.action   = action_s2;

endmodule
